### sv/ppl_pkg.sv
// Shared constants and control types of the pairwise proximity line finder.
`timescale 1ns / 1ps

package ppl_pkg;

    localparam int POINTS_DEF = 64;
    localparam int COORD_W    = 16;
    localparam int THR_W      = 12;
    localparam int IDX_W      = 6;
    localparam int INT_W      = 8;
    localparam int DIST_W     = 12;
    localparam int SQ_W       = 24;
    localparam int D2_W       = 25;
    localparam int SCALE_W    = 16;
    localparam int TGT_W      = D2_W + SCALE_W;
    localparam int TRIAL_W    = INT_W + THR_W;
    localparam int TSQ_W      = 2 * TRIAL_W;
    localparam int PT_W       = 2 * COORD_W;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 88;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // 255 squared, the scale applied to the squared distance.
    localparam logic [SCALE_W-1:0] SCALE_SQ = 16'd65025;

    // Register index of the threshold.
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic [THR_W-1:0] THR_RESET = 12'd100;

    typedef struct packed {
        logic accept;      // take the input transfer
        logic rd_point;    // read stored point i
        logic diff;        // coordinate distances
        logic square;      // squares of the distances
        logic sum;         // squared distance
        logic target;      // scaled target, start of intensity search
        logic trial;       // trial product
        logic trial_sq;    // trial squared
        logic trial_cmp;   // keep or drop the trial bit
        logic next_pair;   // advance to the next stored point
        logic load_pend;   // hit done: move pending line out, hold new one
        logic flush;       // send pending line with last flag
        logic store;       // write the new point
    } ppl_cmd_t;

    typedef struct packed {
        logic full_in;     // offered point would be dropped
        logic empty_in;    // offered point has nothing to compare with
        logic hit;         // current pair is below threshold
        logic bit_done;    // intensity search on its final bit
        logic last_pair;   // current pair is the last stored point
        logic pend_valid;  // a line waits in the pending slot
        logic out_free;    // output register can take a line
    } ppl_status_t;

endpackage

### sv/pairwise_proximity_lines.sv
// Top level of the pairwise proximity line finder: ports, register file, controller and datapath.
`timescale 1ns / 1ps

// Points arrive one per input transfer as unsigned Q12.4 coordinates; a set frame_start
// flag empties the point store first. Each new point is compared, in index order, with
// every point stored earlier in the frame, and for each pair whose integer pixel distance
// is below threshold_distance one line transfer leaves the block, carrying both indices,
// both endpoints and the intensity floor(255 * distance / threshold). The final line of a
// point has tlast set. A point arriving with the store full is dropped without results.
// Per stored point the sequencer reads it, forms and squares the coordinate distances,
// sums the squares and forms the scaled target. A pair below threshold then finds the
// exact intensity one bit at a time over eight bits, each through a trial multiply, a
// squaring multiply and a compare, and pushes its line; last the point is closed out and
// written. The result side can stall a push or the closing flush; the sequencer handles
// one point at a time. Lines are held one step back so that the last one can be flagged,
// and an output register lets the block keep working while a line waits to be taken.
// No clearing pass is needed after reset.

module pairwise_proximity_lines #(
    parameter int POINTS = ppl_pkg::POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Point input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppl_pkg::S_TDATA_W-1:0]   s_tdata,  // x_pos[15:0], y_pos[31:16]
    input  logic [0:0]                      s_tuser,  // frame_start[0]
    // Line output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // index_a[5:0], index_b[11:6], start_x[27:12], start_y[43:28],
    // end_x[59:44], end_y[75:60], intensity[83:76], zero[87:84]
    output logic [ppl_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // Configuration.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppl_pkg::APB_AW-1:0]      paddr,
    input  logic [ppl_pkg::APB_DW-1:0]      pwdata,
    output logic [ppl_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    import ppl_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    logic               reg_sel;
    ppl_cmd_t           cmd;
    ppl_status_t        status;
    logic [IDX_W-1:0]   o_index_a, o_index_b;
    logic [COORD_W-1:0] o_start_x, o_start_y, o_end_x, o_end_y;
    logic [INT_W-1:0]   o_intensity;

    // The only register sits at byte address zero; address four decodes to nothing.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_THRESHOLD) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_THRESHOLD) ? APB_DW'(thr_reg) : '0;

    ppl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppl_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .thr           (thr_reg),
        .in_x          (s_tdata[COORD_W-1:0]),
        .in_y          (s_tdata[PT_W-1:COORD_W]),
        .in_fs         (s_tuser[0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_index_a   (o_index_a),
        .out_index_b   (o_index_b),
        .out_start_x   (o_start_x),
        .out_start_y   (o_start_y),
        .out_end_x     (o_end_x),
        .out_end_y     (o_end_y),
        .out_intensity (o_intensity),
        .out_last      (m_tlast)
    );

    assign m_tdata = {4'd0, o_intensity, o_end_y, o_end_x, o_start_y, o_start_x,
                      o_index_b, o_index_a};

endmodule

### sv/ppl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ppl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/ppl_datapath.sv
// Datapath: point store, distance and intensity arithmetic, pending and output lines.
`timescale 1ns / 1ps

module ppl_datapath #(
    parameter int POINTS = ppl_pkg::POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ppl_pkg::ppl_cmd_t                 cmd,
    output ppl_pkg::ppl_status_t              status,
    input  logic [ppl_pkg::THR_W-1:0]         thr,
    input  logic [ppl_pkg::COORD_W-1:0]       in_x,
    input  logic [ppl_pkg::COORD_W-1:0]       in_y,
    input  logic                              in_fs,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ppl_pkg::IDX_W-1:0]         out_index_a,
    output logic [ppl_pkg::IDX_W-1:0]         out_index_b,
    output logic [ppl_pkg::COORD_W-1:0]       out_start_x,
    output logic [ppl_pkg::COORD_W-1:0]       out_start_y,
    output logic [ppl_pkg::COORD_W-1:0]       out_end_x,
    output logic [ppl_pkg::COORD_W-1:0]       out_end_y,
    output logic [ppl_pkg::INT_W-1:0]         out_intensity,
    output logic                              out_last
);

    import ppl_pkg::*;

    localparam int AW    = $clog2(POINTS);
    localparam int CNT_W = $clog2(POINTS + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   eff_count;
    logic [AW-1:0]      base_reg;
    logic [AW-1:0]      i_reg;
    logic [COORD_W-1:0] nx_reg, ny_reg;
    logic [SQ_W-1:0]    limit_reg;
    logic [PT_W-1:0]    rd_data;
    logic [COORD_W-1:0] px, py, pdx, pdy;
    logic [DIST_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]    dx2_reg, dy2_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [TGT_W-1:0]   target_reg;
    logic [INT_W-1:0]   v_reg, bit_reg;
    logic [TRIAL_W-1:0] trial_reg;
    logic [TSQ_W-1:0]   tsq_reg;

    logic               pend_valid_reg;
    logic [AW-1:0]      pend_idx_reg;
    logic [COORD_W-1:0] pend_x_reg, pend_y_reg;
    logic [INT_W-1:0]   pend_int_reg;
    logic               out_valid_reg;
    logic               out_free;

    assign eff_count = in_fs ? '0 : count_reg;
    assign px        = rd_data[COORD_W-1:0];
    assign py        = rd_data[PT_W-1:COORD_W];
    assign pdx       = (px >= nx_reg) ? px - nx_reg : nx_reg - px;
    assign pdy       = (py >= ny_reg) ? py - ny_reg : ny_reg - py;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        status            = '0;
        status.full_in    = eff_count >= CNT_W'(POINTS);
        status.empty_in   = eff_count == '0;
        status.hit        = D2_W'(limit_reg) > d2_reg;
        status.bit_done   = bit_reg[0];
        status.last_pair  = i_reg == AW'(base_reg - AW'(1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    ppl_ram #(
        .WIDTH (PT_W),
        .DEPTH (POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (base_reg),
        .wdata ({ny_reg, nx_reg}),
        .re    (cmd.rd_point),
        .raddr (i_reg),
        .rdata (rd_data)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            i_reg          <= '0;
            base_reg       <= '0;
        end else begin
            if (cmd.accept) begin
                if (in_fs) begin
                    count_reg <= '0;
                end
                base_reg <= AW'(eff_count);
                i_reg    <= '0;
            end
            if (cmd.next_pair) begin
                i_reg <= i_reg + AW'(1);
            end
            if (cmd.store) begin
                count_reg <= CNT_W'(base_reg) + CNT_W'(1);
            end
            if (cmd.load_pend) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.load_pend && pend_valid_reg) || cmd.flush) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic and payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            nx_reg    <= in_x;
            ny_reg    <= in_y;
            limit_reg <= SQ_W'(thr) * SQ_W'(thr);
        end
        if (cmd.diff) begin
            dx_reg <= pdx[COORD_W-1:4];
            dy_reg <= pdy[COORD_W-1:4];
        end
        if (cmd.square) begin
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
        end
        if (cmd.sum) begin
            d2_reg <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
        end
        if (cmd.target) begin
            target_reg <= TGT_W'(d2_reg) * TGT_W'(SCALE_SQ);
            v_reg      <= '0;
            bit_reg    <= {1'b1, {(INT_W-1){1'b0}}};
        end
        if (cmd.trial) begin
            trial_reg <= TRIAL_W'(v_reg | bit_reg) * TRIAL_W'(thr);
        end
        if (cmd.trial_sq) begin
            tsq_reg <= TSQ_W'(trial_reg) * TSQ_W'(trial_reg);
        end
        if (cmd.trial_cmp) begin
            if (TGT_W'(tsq_reg) <= target_reg) begin
                v_reg <= v_reg | bit_reg;
            end
            bit_reg <= bit_reg >> 1;
        end
        if ((cmd.load_pend && pend_valid_reg) || cmd.flush) begin
            out_index_a   <= IDX_W'(pend_idx_reg);
            out_index_b   <= IDX_W'(base_reg);
            out_start_x   <= pend_x_reg;
            out_start_y   <= pend_y_reg;
            out_end_x     <= nx_reg;
            out_end_y     <= ny_reg;
            out_intensity <= pend_int_reg;
            out_last      <= cmd.flush;
        end
        if (cmd.load_pend) begin
            pend_idx_reg <= i_reg;
            pend_x_reg   <= px;
            pend_y_reg   <= py;
            pend_int_reg <= v_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_idx_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_index_a < out_index_b)
        else $error("line start index not below line end index");

    a_int_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_intensity != {INT_W{1'b1}})
        else $error("intensity reached full scale on an emitted line");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(POINTS))
        else $error("stored point count beyond capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.load_pend && pend_valid_reg) || cmd.flush) |-> out_free)
        else $error("line moved into a busy output register");

endmodule

### sv/ppl_ctrl.sv
// Controller state machine sequencing the per-pair work.
`timescale 1ns / 1ps

module ppl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppl_pkg::ppl_status_t status,
    output ppl_pkg::ppl_cmd_t    cmd
);

    import ppl_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_READ   = 11'b000_0000_0010,
        ST_DIFF   = 11'b000_0000_0100,
        ST_SQUARE = 11'b000_0000_1000,
        ST_SUM    = 11'b000_0001_0000,
        ST_TARGET = 11'b000_0010_0000,
        ST_TRIAL  = 11'b000_0100_0000,
        ST_TSQ    = 11'b000_1000_0000,
        ST_TCMP   = 11'b001_0000_0000,
        ST_PUSH   = 11'b010_0000_0000,
        ST_FLUSH  = 11'b100_0000_0000
    } ppl_state_t;

    ppl_state_t state_reg, state_next;
    logic       store_reg, store_next;

    assign in_ready = (state_reg == ST_IDLE) && !store_reg;

    always_comb begin
        state_next = state_reg;
        store_next = 1'b0;
        cmd        = '0;
        cmd.store  = store_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.accept = 1'b1;
                    if (!status.full_in) begin
                        if (status.empty_in) begin
                            store_next = 1'b1;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                cmd.rd_point = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET: begin
                cmd.target = 1'b1;
                if (status.hit) begin
                    state_next = ST_TRIAL;
                end else if (status.last_pair) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.next_pair = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_TRIAL: begin
                cmd.trial  = 1'b1;
                state_next = ST_TSQ;
            end
            ST_TSQ: begin
                cmd.trial_sq = 1'b1;
                state_next   = ST_TCMP;
            end
            ST_TCMP: begin
                cmd.trial_cmp = 1'b1;
                state_next    = status.bit_done ? ST_PUSH : ST_TRIAL;
            end
            ST_PUSH: begin
                if (!status.pend_valid || status.out_free) begin
                    cmd.load_pend = 1'b1;
                    if (status.last_pair) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.next_pair = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid) begin
                    store_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    store_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            store_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            store_reg <= store_next;
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for the pairwise proximity line finder.
`timescale 1ns / 1ps

module testbench;
    import ppl_pkg::*;

    localparam int STORE_DEPTH = POINTS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [APB_AW-1:0] THR_ADDR = APB_AW'(4 * REG_THRESHOLD);

    // One point offered on the input channel.
    typedef struct packed {
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic        frame_start;
    } point_t;

    // One line expected on the result channel.
    typedef struct packed {
        logic [5:0]  index_a;
        logic [5:0]  index_b;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic [7:0]  intensity;
        logic        last_line;
    } line_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;   // x_pos[15:0], y_pos[31:16]
    logic [0:0]               s_tuser;   // frame_start[0]
    logic                     m_tvalid;
    logic                     m_tready;
    // index_a, index_b, start_x, start_y, end_x, end_y, intensity, zero pad
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    pairwise_proximity_lines dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predictor state: a private copy of the point store, its fill level and
    // the threshold currently programmed into the block.
    logic [31:0]  model_points [STORE_DEPTH];
    int unsigned  model_count;
    logic [11:0]  model_threshold;

    point_t pending_points[$];
    line_t  expected_lines[$];

    int error_count;
    int idle_cycles;
    bit stimulus_done;

    // Exact intensity: largest v with (v*thr)^2 <= 65025*d2, built one bit at a time.
    function automatic logic [7:0] exact_intensity(longint unsigned d2, longint unsigned thr);
        longint unsigned goal;
        longint unsigned trial;
        logic [7:0]      v;
        goal = 65025 * d2;
        v = '0;
        for (int b = 7; b >= 0; b--) begin
            trial = longint'(v | (8'd1 << b)) * thr;
            if (trial * trial <= goal)
                v = v | (8'd1 << b);
        end
        return v;
    endfunction

    // Works out the lines that one accepted point causes and updates the store.
    task automatic predict_lines(input point_t pt);
        longint unsigned dx, dy, d2, limit;
        logic [15:0]     px, py;
        line_t           ln;
        int              first_new;
        first_new = expected_lines.size();
        limit = longint'(model_threshold) * longint'(model_threshold);
        if (pt.frame_start)
            model_count = 0;
        // A full store drops the point entirely.
        if (model_count >= STORE_DEPTH)
            return;
        for (int i = 0; i < model_count; i++) begin
            px = model_points[i][15:0];
            py = model_points[i][31:16];
            dx = ((px >= pt.x_pos) ? px - pt.x_pos : pt.x_pos - px) >> 4;
            dy = ((py >= pt.y_pos) ? py - pt.y_pos : pt.y_pos - py) >> 4;
            d2 = dx * dx + dy * dy;
            if (d2 < limit) begin
                ln.index_a   = i[5:0];
                ln.index_b   = model_count[5:0];
                ln.start_x   = px;
                ln.start_y   = py;
                ln.end_x     = pt.x_pos;
                ln.end_y     = pt.y_pos;
                ln.intensity = exact_intensity(d2, model_threshold);
                ln.last_line = 1'b0;
                expected_lines.push_back(ln);
            end
        end
        if (expected_lines.size() > first_new)
            expected_lines[expected_lines.size() - 1].last_line = 1'b1;
        model_points[model_count] = {pt.y_pos, pt.x_pos};
        model_count++;
    endtask

    // Driver: bursts of transfers separated by random gaps. The next point is
    // loaded at the same edge that completes the previous transfer, so tvalid
    // is never dropped and raised within one step.
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_lines(pending_points.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_points[0].y_pos, pending_points[0].x_pos};
                    s_tuser  <= pending_points[0].frame_start;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure follows its own pattern: phases of steady
    // acceptance alternate with phases of random stalls.
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 60)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(3) != 0);
        end
    end

    // Monitor: checks every line transfer against the oldest expectation.
    line_t got_line;
    line_t want_line;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_line.index_a   = m_tdata[5:0];
            got_line.index_b   = m_tdata[11:6];
            got_line.start_x   = m_tdata[27:12];
            got_line.start_y   = m_tdata[43:28];
            got_line.end_x     = m_tdata[59:44];
            got_line.end_y     = m_tdata[75:60];
            got_line.intensity = m_tdata[83:76];
            got_line.last_line = m_tlast;
            if (expected_lines.size() == 0) begin
                $error("unexpected line transfer %h last %b", m_tdata, m_tlast);
                error_count++;
            end else begin
                want_line = expected_lines.pop_front();
                if (got_line.index_a !== want_line.index_a) begin
                    $error("index_a: expected %0d actual %0d", want_line.index_a, got_line.index_a);
                    error_count++;
                end
                if (got_line.index_b !== want_line.index_b) begin
                    $error("index_b: expected %0d actual %0d", want_line.index_b, got_line.index_b);
                    error_count++;
                end
                if (got_line.start_x !== want_line.start_x) begin
                    $error("start_x: expected %h actual %h", want_line.start_x, got_line.start_x);
                    error_count++;
                end
                if (got_line.start_y !== want_line.start_y) begin
                    $error("start_y: expected %h actual %h", want_line.start_y, got_line.start_y);
                    error_count++;
                end
                if (got_line.end_x !== want_line.end_x) begin
                    $error("end_x: expected %h actual %h", want_line.end_x, got_line.end_x);
                    error_count++;
                end
                if (got_line.end_y !== want_line.end_y) begin
                    $error("end_y: expected %h actual %h", want_line.end_y, got_line.end_y);
                    error_count++;
                end
                if (got_line.intensity !== want_line.intensity) begin
                    $error("intensity: expected %0d actual %0d", want_line.intensity,
                           got_line.intensity);
                    error_count++;
                end
                if (got_line.last_line !== want_line.last_line) begin
                    $error("last_line: expected %b actual %b", want_line.last_line,
                           got_line.last_line);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles without any transfer on either channel. The
    // slowest point meets 63 stored points, each a possible hit and possibly stalled.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (!stimulus_done || expected_lines.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Writes one register through the configuration port while the block idles.
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_threshold = value[11:0];
    endtask

    // Waits until all queued points are taken and all lines are out, then
    // lets the block finish the tail of a point that caused no line.
    task automatic drain_block();
        while (pending_points.size() > 0 || s_tvalid || expected_lines.size() > 0)
            @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    function automatic point_t make_point(input logic [15:0] x, input logic [15:0] y,
                                          input logic fs);
        point_t p;
        p.x_pos = x;
        p.y_pos = y;
        p.frame_start = fs;
        return p;
    endfunction

    // Random frame: points clustered around a center so that many pairs fall
    // under the threshold, with a share of scattered points anywhere.
    task automatic queue_random_frame(input int n_points, input int spread);
        logic [15:0] cx, cy;
        logic [15:0] x, y;
        cx = $urandom;
        cy = $urandom;
        for (int i = 0; i < n_points; i++) begin
            if ($urandom_range(4) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = cx + 16'($urandom_range(spread)) - 16'(spread / 2);
                y = cy + 16'($urandom_range(spread)) - 16'(spread / 2);
            end
            // Occasional stray frame starts break a frame early.
            pending_points.push_back(make_point(x, y, (i == 0) || ($urandom_range(40) == 0)));
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count = 0;
        idle_cycles = 0;
        stimulus_done = 1'b0;
        model_count = 0;
        model_threshold = THR_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset threshold: first point of a frame, the
        // coordinate extremes, a pair at exactly the threshold and just under it,
        // and fractional bits that truncate away.
        pending_points.push_back(make_point(16'h0000, 16'h0000, 1'b1));
        pending_points.push_back(make_point(16'h0000, 16'h0000, 1'b0));
        pending_points.push_back(make_point(16'h063F, 16'h0000, 1'b0));
        pending_points.push_back(make_point(16'h0640, 16'h0000, 1'b0));
        pending_points.push_back(make_point(16'h000F, 16'h0630, 1'b0));
        pending_points.push_back(make_point(16'hFFFF, 16'hFFFF, 1'b1));
        pending_points.push_back(make_point(16'hFFF0, 16'hFFFF, 1'b0));
        pending_points.push_back(make_point(16'h5555, 16'hAAAA, 1'b0));
        drain_block();

        // Largest threshold: every pair closer than 4095 pixels joins.
        write_register(THR_ADDR, 32'd4095);
        pending_points.push_back(make_point(16'h0000, 16'hFFFF, 1'b1));
        pending_points.push_back(make_point(16'hFFFF, 16'h0000, 1'b0));
        pending_points.push_back(make_point(16'h8000, 16'h8000, 1'b0));
        pending_points.push_back(make_point(16'hAAAA, 16'h5555, 1'b0));
        drain_block();

        // Smallest threshold: only pairs within the same pixel join.
        write_register(THR_ADDR, 32'd1);
        pending_points.push_back(make_point(16'h1230, 16'h4560, 1'b1));
        pending_points.push_back(make_point(16'h123F, 16'h456F, 1'b0));
        pending_points.push_back(make_point(16'h1240, 16'h4560, 1'b0));
        drain_block();

        // Zero threshold written through the low 12 bits: no line ever.
        write_register(THR_ADDR, 32'hFFFF_F000);
        pending_points.push_back(make_point(16'h0100, 16'h0100, 1'b1));
        pending_points.push_back(make_point(16'h0100, 16'h0100, 1'b0));
        drain_block();

        // Full store: 64 coincident-free points fill it, then two more are dropped.
        write_register(THR_ADDR, 32'd3);
        for (int i = 0; i < STORE_DEPTH + 2; i++)
            pending_points.push_back(make_point(16'(i * 48), 16'(i * 16), i == 0));
        drain_block();

        // Random part over several thresholds, extremes included.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_register(THR_ADDR, 32'd100);
                1: write_register(THR_ADDR, 32'd4095);
                2: write_register(THR_ADDR, 32'd1);
                default: write_register(THR_ADDR, 32'($urandom_range(4095)));
            endcase
            for (int f = 0; f < 4; f++)
                queue_random_frame($urandom_range(24, 2), $urandom_range(3000, 64));
            drain_block();
        end
        stimulus_done = 1'b1;

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### files.f
sv/ppl_pkg.sv
sv/ppl_ram.sv
sv/ppl_datapath.sv
sv/ppl_ctrl.sv
sv/pairwise_proximity_lines.sv
verif/testbench.sv
